[src/sst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg
// Opcodes and status codes of the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int unsigned ELEM_W = 8;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_MEMBER = 2'd2,
        OP_SPARE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_PRESENT   = 2'd3
    } t_status;

endpackage
`default_nettype wire

[src/sst_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[src/sorted_set_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_table_unit
// Set of bytes kept as an ascending linked list in a node RAM with a free list.
// sequence: accept, walk of the list (one elem and link RAM read per node),
//   update states S_INS, S_LINK1, S_LINK2 as needed, S_DONE to output register
// one item at a time; S_DONE waits while the output register is still full
// reset: synchronous; a clearing pass rebuilds the free list in the link RAM,
//   no item is taken until it ends
// ----------------------------------------------------------------------------
module sorted_set_table_unit #(
    parameter int unsigned NODE_COUNT = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_opcode,
    input  wire sst_pkg::t_elem    i_element,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_status,
    output logic                   o_present
);

    import sst_pkg::*;

    localparam int unsigned AW = $clog2(NODE_COUNT);
    localparam int unsigned LW = $clog2(NODE_COUNT + 1);
    localparam logic [LW-1:0] NIL   = {LW{1'b1}};
    localparam logic [LW-1:0] NODES = LW'(NODE_COUNT);
    localparam logic [AW-1:0] LAST  = AW'(NODE_COUNT - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_INS   = 7'b0001000,
        S_LINK1 = 7'b0010000,
        S_LINK2 = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_steps, n_steps;
    logic [LW-1:0] r_stop, n_stop;
    logic [LW-1:0] r_lval, n_lval;
    t_opcode       r_op, n_op;
    t_elem         r_key, n_key;
    t_status       r_res_status, n_res_status;
    logic          r_res_present, n_res_present;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic          r_out_present, n_out_present;

    logic          elem_we;
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [AW-1:0] raddr;
    t_elem         rd_elem;
    logic [LW-1:0] rd_link;

    logic          cur_ok;
    logic          prev_ok;
    logic          free_ok;
    logic          stop_ok;
    logic          found;
    logic          go_on;
    logic          out_free;

    sst_ram #(.WIDTH(ELEM_W), .DEPTH(NODE_COUNT)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (r_free[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (raddr),
        .o_rdata (rd_elem)
    );

    sst_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_link)
    );

    assign cur_ok   = (r_cur < NODES);
    assign prev_ok  = (r_prev < NODES);
    assign free_ok  = (r_free < NODES);
    assign stop_ok  = cur_ok && (r_steps < NODES);
    assign go_on    = stop_ok && (rd_elem < r_key);
    assign found    = stop_ok && (rd_elem == r_key);
    assign out_free = !r_out_valid || i_ready;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_present = r_out_present;

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_head        = r_head;
        n_free        = r_free;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_steps       = r_steps;
        n_stop        = r_stop;
        n_lval        = r_lval;
        n_op          = r_op;
        n_key         = r_key;
        n_res_status  = r_res_status;
        n_res_present = r_res_present;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_status  = r_out_status;
        n_out_present = r_out_present;
        elem_we       = 1'b0;
        link_we       = 1'b0;
        link_waddr    = r_clr;
        link_wdata    = r_lval;
        raddr         = r_cur[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr;
                link_wdata = (r_clr == '0) ? NIL : (LW'(r_clr) - LW'(1));
                n_clr      = r_clr + AW'(1);
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = r_head[AW-1:0];
                if (i_valid) begin
                    n_op    = t_opcode'(i_opcode);
                    n_key   = i_element;
                    n_cur   = r_head;
                    n_prev  = NIL;
                    n_steps = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (go_on) begin
                    // step to the next node, read issued straight from the link
                    n_prev  = r_cur;
                    n_cur   = rd_link;
                    n_steps = r_steps + LW'(1);
                    raddr   = rd_link[AW-1:0];
                end else begin
                    n_stop        = stop_ok ? r_cur : NIL;
                    n_res_present = found;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (found) begin
                                n_res_status = ST_PRESENT;
                                n_state      = S_DONE;
                            end else if (free_ok) begin
                                raddr        = r_free[AW-1:0];
                                n_res_status = ST_DONE;
                                n_state      = S_INS;
                            end else begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end
                        end
                        OP_DELETE: begin
                            n_lval = rd_link;
                            if (found) begin
                                n_res_status = ST_DONE;
                                n_state      = S_LINK1;
                            end else begin
                                n_res_status = ST_NOT_FOUND;
                                n_state      = S_DONE;
                            end
                        end
                        OP_MEMBER, OP_SPARE: begin
                            n_res_status = found ? ST_DONE : ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end
                        default: begin
                            n_res_status = found ? ST_DONE : ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                // new node takes the key and points at the stop node
                elem_we    = 1'b1;
                link_we    = 1'b1;
                link_waddr = r_free[AW-1:0];
                link_wdata = r_stop;
                n_lval     = r_free;
                n_free     = rd_link;
                n_state    = S_LINK1;
            end
            S_LINK1: begin
                if (prev_ok) begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[AW-1:0];
                    link_wdata = r_lval;
                end else begin
                    n_head = r_lval;
                end
                n_state = (r_op == OP_DELETE) ? S_LINK2 : S_DONE;
            end
            S_LINK2: begin
                // push the unlinked node on the free list
                link_we    = 1'b1;
                link_waddr = r_stop[AW-1:0];
                link_wdata = r_free;
                n_free     = r_stop;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_present = r_res_present;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= NIL;
            r_free      <= LW'(NODE_COUNT - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_steps       <= n_steps;
        r_stop        <= n_stop;
        r_lval        <= n_lval;
        r_op          <= n_op;
        r_key         <= n_key;
        r_res_status  <= n_res_status;
        r_res_present <= n_res_present;
        r_out_status  <= n_out_status;
        r_out_present <= n_out_present;
    end

endmodule
`default_nettype wire
